/* rtl/swm_pkg.sv */
// shared types and constants for the sliding window median core
// no dependencies
package swm_pkg;

  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned ADDR_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned RESET_SIZE = 3;

  // contents of one cell: a sample and how many samples arrived after it
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [ADDR_W-1:0]        age;
  } swm_tap_t;

  // what a cell hands to its right neighbor: the entry it holds once the
  // leaving sample is squeezed out, and whether that entry sorts above the new word
  typedef struct packed {
    swm_tap_t w;
    logic     gt;
  } swm_link_t;

endpackage

/* rtl/swm_cell.sv */
// one cell of the sorted window row: holds one sample and its age
// depends on swm_pkg
module swm_cell import swm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     shift_i,   // leaving entry sits at or left of this cell
  input  logic                     wvalid_i,  // squeezed entry at this place is in use
  input  swm_tap_t                 right_i,
  input  swm_link_t                left_i,
  output swm_tap_t                 own_o,
  output swm_link_t                link_o
);

  swm_tap_t cell_q, cell_d;
  swm_tap_t w;
  logic     gtw;

  assign w      = shift_i ? right_i : cell_q;
  assign gtw    = !wvalid_i || ($signed(w.value) > $signed(sample_i));
  assign own_o  = cell_q;
  assign link_o = '{w: w, gt: gtw};

  always_comb begin
    cell_d = cell_q;
    if (en_i) begin
      if (!gtw) begin
        cell_d.value = w.value;
        cell_d.age   = w.age + ADDR_W'(1);
      end else if (!left_i.gt) begin
        // insertion point of the new word
        cell_d.value = sample_i;
        cell_d.age   = '0;
      end else begin
        cell_d.value = left_i.w.value;
        cell_d.age   = left_i.w.age + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

endmodule

/* rtl/sliding_window_median_core.sv */
// top level of the sliding window median core: control, cell row, output register
// depends on swm_pkg and swm_cell
//
// Takes one signed 32-bit sample per word and gives the lower median of the
// last window_size samples (position (window_size-1)/2 of the sorted window)
// once the window is full; the first window_size-1 samples after reset or a
// size write give no result. A size of 0 acts as 1 and sizes above 64 act as
// 64. The window sits in a row of 64 cells kept in sorted order, each holding
// a sample and its age; for each accepted sample every cell compares it with
// its entry, the oldest entry drops out and the new one slides in at once, so a
// sample is accepted every cycle unless a median is pending. Each median is
// picked from the row into the output register once that register is free or
// being read. Writing window_size clears the window; write it only while idle.
module sliding_window_median_core import swm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_W-1:0]         window_size_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DATA_W-1:0] sample_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] median_o
);

  logic [CFG_W-1:0]  win_size_q, win_size_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] median_q;

  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  n_eff;
  logic              full;
  logic              accept;
  logic              gives_result;
  logic              move;
  logic [ADDR_W-1:0] med_idx;
  logic [ADDR_W-1:0] oldest_age;

  swm_tap_t  own   [MAX_WINDOW];
  swm_link_t link  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] del_here;
  logic [MAX_WINDOW-1:0] shift;
  logic [MAX_WINDOW-1:0] wvalid;

  // active window size, clamped to 1..MAX_WINDOW
  always_comb begin
    if (win_size_q == '0) begin
      size = CNT_W'(1);
    end else if (win_size_q > CFG_W'(MAX_WINDOW)) begin
      size = CNT_W'(MAX_WINDOW);
    end else begin
      size = CNT_W'(win_size_q);
    end
  end

  assign full         = (fill_q == size);
  assign n_eff        = full ? (size - CNT_W'(1)) : fill_q;
  assign oldest_age   = ADDR_W'(size - CNT_W'(1));
  assign med_idx      = ADDR_W'((size - CNT_W'(1)) >> 1);
  assign gives_result = full || ((fill_q + CNT_W'(1)) == size);

  assign move       = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || move;
  assign accept     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_flags
    assign del_here[i] = full && (CNT_W'(i) < size) && (own[i].age == oldest_age);
    assign wvalid[i]   = CNT_W'(i) < n_eff;
    // leaving entry at or left of cell i
    assign shift[i]    = |(del_here & {{(MAX_WINDOW-1){1'b0}}, 1'b1} << i
                           | del_here & ((MAX_WINDOW'(1) << i) - MAX_WINDOW'(1)));
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_tap_t  right;
    swm_link_t left;
    if (i == MAX_WINDOW - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = own[i+1];
    end
    if (i == 0) begin : g_first
      assign left = '{w: '0, gt: 1'b0};
    end else begin : g_rest
      assign left = link[i-1];
    end
    swm_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (accept),
      .sample_i (sample_i),
      .shift_i  (shift[i]),
      .wvalid_i (wvalid[i]),
      .right_i  (right),
      .left_i   (left),
      .own_o    (own[i]),
      .link_o   (link[i])
    );
  end

  always_comb begin
    win_size_d  = win_size_q;
    fill_d      = fill_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (move) begin
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
    end
    if (accept) begin
      if (!full) begin
        fill_d = fill_q + CNT_W'(1);
      end
      if (gives_result) begin
        pend_d = 1'b1;
      end
    end
    if (cfg_valid_i) begin
      win_size_d = window_size_i;
      fill_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q  <= CFG_W'(RESET_SIZE);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_size_q  <= win_size_d;
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      median_q <= own[med_idx].value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

endmodule

/* test/swm_median_checker.sv */
// checker for the sliding window median core: watches the size, sample and median channels,
// keeps its own sorted window and compares every median word against the expected one
// depends on swm_pkg
module swm_median_checker import swm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_W-1:0]         window_size_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] median_i,
  output int                       pending_o,
  output int                       mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [DATA_W-1:0] word_t;

  word_t       arrival [MAX_WINDOW];
  word_t       ranked [MAX_WINDOW];
  word_t       median_due [$];
  int unsigned held;
  int unsigned oldest_slot;
  logic [CFG_W-1:0] size_reg;
  int          errors = 0;

  assign mismatches_o = errors;

  task report_mismatch(input string what, input word_t got, input word_t want);
    $display("%0t: %s mismatch: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // 0 behaves as 1, anything above the row length saturates
  function int unsigned live_size();
    if (size_reg == '0) return 1;
    if (size_reg > MAX_WINDOW) return MAX_WINDOW;
    return int'(size_reg);
  endfunction

  task ranked_insert(input int unsigned count, input word_t s);
    int unsigned i;
    i = count;
    while (i > 0 && ranked[i-1] > s) begin
      ranked[i] = ranked[i-1];
      i--;
    end
    ranked[i] = s;
  endtask

  // drops one copy of the leaving sample, duplicates keep the rest
  task ranked_remove(input int unsigned count, input word_t s);
    int unsigned i;
    i = 0;
    while (i < count && ranked[i] != s) i++;
    while (i + 1 < count) begin
      ranked[i] = ranked[i+1];
      i++;
    end
  endtask

  task slide_window(input word_t s, output bit emits, output word_t med);
    int unsigned n;
    word_t leaving;
    n = live_size();
    emits = 1'b0;
    med = '0;
    if (held < n) begin
      arrival[held] = s;
      ranked_insert(held, s);
      held++;
      if (held < n) return;
      oldest_slot = 0;
    end else begin
      leaving = arrival[oldest_slot];
      arrival[oldest_slot] = s;
      oldest_slot = (oldest_slot + 1 >= n) ? 0 : oldest_slot + 1;
      ranked_remove(n, leaving);
      ranked_insert(n - 1, s);
    end
    emits = 1'b1;
    med = ranked[(n - 1) / 2];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bit    emits;
    word_t want;
    if (!rst_ni) begin
      size_reg = CFG_W'(RESET_SIZE);
      held = 0;
      oldest_slot = 0;
      median_due.delete();
      pending_o <= 0;
    end else begin
      // a size write restarts the window empty
      if (cfg_valid_i && cfg_ready_i) begin
        size_reg = window_size_i;
        held = 0;
        oldest_slot = 0;
      end
      if (in_valid_i && in_ready_i) begin
        slide_window(sample_i, emits, want);
        if (emits) median_due.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (median_due.size() == 0) begin
          report_mismatch("unexpected median", median_i, 'x);
        end else begin
          want = median_due.pop_front();
          if (median_i !== want) report_mismatch("median", median_i, want);
        end
      end
      pending_o <= median_due.size();
    end
  end

endmodule

/* test/tb.sv */
// testbench top for the sliding window median core: clock, reset, sample stimulus,
// size writes, output backpressure, watchdog and verdict
// depends on swm_pkg, sliding_window_median_core and swm_median_checker
module tb import swm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 1550;
  localparam int OPENING_LEN = 18;

  logic                     clk = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         window_size = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] sample = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] median;
  int                       pending;
  int                       mismatches;

  int sent_count = 0;
  int quiet = 0;
  int hold_left = 0;
  int seg_left = 0;
  int ready_mode = 0;
  bit hold_done = 1'b0;

  // extremes, equal runs and near-extremes at the reset size of 3
  logic signed [DATA_W-1:0] opening [OPENING_LEN] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, -32'sd1, -32'sd1,
    32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
    32'sd5, 32'sd5, 32'sd1, 32'sd2, 32'sd3, 32'sh8000_0001, 32'sh7fff_fffe
  };

  sliding_window_median_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .window_size_i (window_size),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_i      (sample),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .median_o      (median)
  );

  swm_median_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .window_size_i (window_size),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .sample_i      (sample),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .median_i      (median),
    .pending_o     (pending),
    .mismatches_o  (mismatches)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (in_valid && in_ready) sent_count <= sent_count + 1;
  end

  // receiver: random stall modes per segment, one long hold-off mid run
  always @(posedge clk) begin
    if (!hold_done && sent_count >= 600) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 120);
        ready_mode = $urandom_range(0, 3);
      end
      seg_left--;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((seg_left % 16) >= 5);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return int'($urandom_range(0, 8)) - 4;
      7:          return 32'sh7fff_ffff;
      8:          return 32'sh8000_0000;
      default:    return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] size_for_phase(input int p);
    case (p)
      0: return 7'd1;
      1: return 7'd0;
      2: return 7'd127;
      3: return 7'd64;
      4: return 7'd2;
      5: return 7'd65;
      6: return 7'd5;
      7: return 7'd3;
      default: return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                  : 7'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send_sample(input logic signed [DATA_W-1:0] s);
    in_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every median has come out, plus pipeline slack
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    window_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int k;
    int j;
    int burst;
    int gap;
    int total;
    int phase;
    int n_items;
    int pause_at;
    int eff;
    logic [CFG_W-1:0] size_now;

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    for (k = 0; k < OPENING_LEN; k++) send_sample(opening[k]);
    total = OPENING_LEN;

    phase = 0;
    while (total < ITEM_TARGET) begin
      size_now = size_for_phase(phase);
      eff = (size_now == 0) ? 1 : ((size_now > MAX_WINDOW) ? MAX_WINDOW : size_now);
      n_items = (eff > 32) ? 180 : 80;
      pause_at = (phase == 2 || $urandom_range(0, 3) == 0) ?
                 $urandom_range(10, n_items - 10) : -1;
      settle();
      write_size(size_now);
      k = 0;
      while (k < n_items) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
        for (j = 0; j < burst && k < n_items; j++) begin
          if (k == pause_at) settle();
          send_sample(pick_sample());
          k++;
          total++;
        end
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      phase++;
    end

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_median_core.sv
test/swm_median_checker.sv
test/tb.sv
